// ===== rtl/core/upz_pkg.sv =====
// Shared types and constants for the ultrasonic proximity zoner.
`timescale 1ns / 1ps
`default_nettype none

package upz_pkg;

  // Field widths
  localparam int unsigned ECHO_W  = 16;
  localparam int unsigned DIST_W  = 11;
  localparam int unsigned LAMP_W  = 3;
  localparam int unsigned ALERT_W = 2;

  // Echo ticks to centimetres: x / 58 == (x * 36158) >> 21 for all 16-bit x
  localparam int unsigned CM_RECIP_W  = 16;
  localparam int unsigned CM_SHIFT    = 21;
  localparam logic [CM_RECIP_W-1:0] CM_RECIP = 16'd36158;

  // Filter sum / 6 == (sum * 2731) >> 14 for all sums up to 6 * 1129
  localparam int unsigned SUM_W        = 13;
  localparam int unsigned SIX_RECIP_W  = 12;
  localparam int unsigned SIX_SHIFT    = 14;
  localparam logic [SIX_RECIP_W-1:0] SIX_RECIP = 12'd2731;

  // Queue between front and back; depth must be a power of two
  localparam int unsigned QUEUE_DEPTH = 2;

  // Lamp codes
  localparam logic [LAMP_W-1:0] LAMP_RED    = 3'd0;
  localparam logic [LAMP_W-1:0] LAMP_ORANGE = 3'd1;
  localparam logic [LAMP_W-1:0] LAMP_YELLOW = 3'd2;
  localparam logic [LAMP_W-1:0] LAMP_GREEN  = 3'd3;
  localparam logic [LAMP_W-1:0] LAMP_OFF    = 3'd4;

  // Alert codes
  localparam logic [ALERT_W-1:0] ALERT_NONE   = 2'd0;
  localparam logic [ALERT_W-1:0] ALERT_DOUBLE = 2'd1;
  localparam logic [ALERT_W-1:0] ALERT_QUAD   = 2'd2;

  // Threshold reset values
  localparam logic [DIST_W-1:0] REAR_LIMIT0_RST = 11'd10;
  localparam logic [DIST_W-1:0] REAR_LIMIT1_RST = 11'd20;
  localparam logic [DIST_W-1:0] REAR_LIMIT2_RST = 11'd30;
  localparam logic [DIST_W-1:0] FWD_LIMIT0_RST  = 11'd20;
  localparam logic [DIST_W-1:0] FWD_LIMIT1_RST  = 11'd40;

  // Converted item passed from front to back
  typedef struct packed {
    logic [DIST_W-1:0] rear_cm;
    logic [DIST_W-1:0] forward_cm;
    logic              mode_press;
    logic              select_press;
  } upz_item_t;

  // One result item
  typedef struct packed {
    logic [DIST_W-1:0]  rear_distance;
    logic [DIST_W-1:0]  forward_distance;
    logic               shown_channel;
    logic               in_setup;
    logic [LAMP_W-1:0]  lamp;
    logic [ALERT_W-1:0] alert;
    logic               rejected;
  } upz_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/upz_front.sv =====
// Front stage: accept an input item and convert both echo counts to centimetres.
`timescale 1ns / 1ps
`default_nettype none

module upz_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire logic [upz_pkg::ECHO_W-1:0]     rear_echo_count,
  input  wire logic [upz_pkg::ECHO_W-1:0]     forward_echo_count,
  input  wire logic                           mode_press,
  input  wire logic                           select_press,
  output      logic                           push,
  output      upz_pkg::upz_item_t             item,
  input  wire logic                           queue_full
);

  localparam int unsigned PROD_W = upz_pkg::ECHO_W + upz_pkg::CM_RECIP_W;

  logic              held;
  logic              take;
  logic [PROD_W-1:0] rear_prod;
  logic [PROD_W-1:0] fwd_prod;

  // Hold the item while the queue is full
  assign push     = held && !queue_full;
  assign in_stall = held && queue_full;
  assign take     = in_valid && !in_stall;

  // Divide by 58 through the reciprocal
  assign rear_prod = PROD_W'(rear_echo_count) * PROD_W'(upz_pkg::CM_RECIP);
  assign fwd_prod  = PROD_W'(forward_echo_count) * PROD_W'(upz_pkg::CM_RECIP);

  // Valid flag of the front register
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  // Payload of the front register
  always_ff @(posedge clk) begin
    if (take) begin
      item.rear_cm      <= rear_prod[upz_pkg::CM_SHIFT +: upz_pkg::DIST_W];
      item.forward_cm   <= fwd_prod[upz_pkg::CM_SHIFT +: upz_pkg::DIST_W];
      item.mode_press   <= mode_press;
      item.select_press <= select_press;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/upz_queue.sv =====
// Short item queue that decouples the front and back stages.
`timescale 1ns / 1ps
`default_nettype none

module upz_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire upz_pkg::upz_item_t din,
  output      logic               full,
  input  wire logic               pop,
  output      upz_pkg::upz_item_t dout,
  output      logic               empty
);

  localparam int unsigned PTR_W = $clog2(upz_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(upz_pkg::QUEUE_DEPTH + 1);

  upz_pkg::upz_item_t entries [upz_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full  = (count == CNT_W'(upz_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign dout  = entries[rd_ptr];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/upz_back.sv =====
// Back stage: filter distances, run the mode/threshold logic and hold the result.
`timescale 1ns / 1ps
`default_nettype none

module upz_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               queue_empty,
  input  wire upz_pkg::upz_item_t item,
  output      logic               pop,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      upz_pkg::upz_result_t result
);

  localparam int unsigned PROD_W = upz_pkg::SUM_W + upz_pkg::SIX_RECIP_W;
  localparam int unsigned DW     = upz_pkg::DIST_W;

  // Rear threshold capture steps
  localparam logic [1:0] RSTEP_FIRST  = 2'd0;
  localparam logic [1:0] RSTEP_SECOND = 2'd1;
  localparam logic [1:0] RSTEP_THIRD  = 2'd2;

  // Filter taps: one and two items back
  logic [DW-1:0] rear_tap0, rear_tap1, fwd_tap0, fwd_tap1;

  logic [DW-1:0] rear_limit0, rear_limit1, rear_limit2;
  logic [DW-1:0] fwd_limit0, fwd_limit1;
  logic          setup_flag, channel_flag;
  logic [1:0]    rear_step;
  logic          fwd_step;

  logic [DW-1:0] rear_limit0_next, rear_limit1_next, rear_limit2_next;
  logic [DW-1:0] fwd_limit0_next, fwd_limit1_next;
  logic          setup_flag_next, channel_flag_next;
  logic [1:0]    rear_step_next;
  logic          fwd_step_next;

  logic [upz_pkg::SUM_W-1:0] rear_sum, fwd_sum;
  logic [PROD_W-1:0]         rear_prod, fwd_prod;
  logic [DW-1:0]             rd, fd;
  logic                      rej;
  logic [upz_pkg::LAMP_W-1:0]  lamp;
  logic [upz_pkg::ALERT_W-1:0] alert;

  assign pop = !queue_empty && (!out_valid || !out_stall);

  // Weighted three-tap filter, divide by 6 through the reciprocal
  assign rear_sum  = upz_pkg::SUM_W'(rear_tap1) + {rear_tap0, 2'b00}
                   + upz_pkg::SUM_W'(item.rear_cm);
  assign fwd_sum   = upz_pkg::SUM_W'(fwd_tap1) + {fwd_tap0, 2'b00}
                   + upz_pkg::SUM_W'(item.forward_cm);
  assign rear_prod = PROD_W'(rear_sum) * PROD_W'(upz_pkg::SIX_RECIP);
  assign fwd_prod  = PROD_W'(fwd_sum) * PROD_W'(upz_pkg::SIX_RECIP);
  assign rd        = rear_prod[upz_pkg::SIX_SHIFT +: DW];
  assign fd        = fwd_prod[upz_pkg::SIX_SHIFT +: DW];

  // Mode toggle, then select press in the resulting mode
  always_comb begin
    rear_limit0_next  = rear_limit0;
    rear_limit1_next  = rear_limit1;
    rear_limit2_next  = rear_limit2;
    fwd_limit0_next   = fwd_limit0;
    fwd_limit1_next   = fwd_limit1;
    channel_flag_next = channel_flag;
    setup_flag_next   = setup_flag ^ item.mode_press;
    rear_step_next    = item.mode_press ? RSTEP_FIRST : rear_step;
    fwd_step_next     = item.mode_press ? 1'b0 : fwd_step;
    rej               = 1'b0;
    if (item.select_press) begin
      if (!setup_flag_next) begin
        channel_flag_next = !channel_flag;
      end else if (!channel_flag) begin
        case (rear_step_next)
          RSTEP_FIRST: begin
            rear_limit0_next = rd;
            rear_step_next   = RSTEP_SECOND;
          end
          RSTEP_SECOND: begin
            if (rd <= rear_limit0) begin
              rej = 1'b1;
            end else begin
              rear_limit1_next = rd;
              rear_step_next   = RSTEP_THIRD;
            end
          end
          RSTEP_THIRD: begin
            if (rd <= rear_limit1) begin
              rej = 1'b1;
            end else begin
              rear_limit2_next = rd;
              rear_step_next   = RSTEP_FIRST;
              setup_flag_next  = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end else if (!fwd_step_next) begin
        fwd_limit0_next = fd;
        fwd_step_next   = 1'b1;
      end else if (fd <= fwd_limit0) begin
        rej = 1'b1;
      end else begin
        fwd_limit1_next = fd;
        fwd_step_next   = 1'b0;
        setup_flag_next = 1'b0;
      end
    end
  end

  // Lamp and alert from the updated state
  always_comb begin
    lamp  = upz_pkg::LAMP_OFF;
    alert = upz_pkg::ALERT_NONE;
    if (!setup_flag_next) begin
      if (!channel_flag_next) begin
        if (rd <= rear_limit0_next) begin
          lamp = upz_pkg::LAMP_RED;
        end else if (rd <= rear_limit1_next) begin
          lamp = upz_pkg::LAMP_ORANGE;
        end else if (rd <= rear_limit2_next) begin
          lamp = upz_pkg::LAMP_YELLOW;
        end else begin
          lamp = upz_pkg::LAMP_GREEN;
        end
      end else if (fd <= fwd_limit0_next) begin
        alert = upz_pkg::ALERT_QUAD;
      end else if (fd <= fwd_limit1_next) begin
        alert = upz_pkg::ALERT_DOUBLE;
      end
    end else if (!channel_flag_next) begin
      case (rear_step_next)
        RSTEP_FIRST:  lamp = upz_pkg::LAMP_RED;
        RSTEP_SECOND: lamp = upz_pkg::LAMP_ORANGE;
        RSTEP_THIRD:  lamp = upz_pkg::LAMP_YELLOW;
        default:      lamp = upz_pkg::LAMP_OFF;
      endcase
    end else begin
      lamp = fwd_step_next ? upz_pkg::LAMP_ORANGE : upz_pkg::LAMP_RED;
    end
  end

  // Update state on each popped item
  always_ff @(posedge clk) begin
    if (rst) begin
      rear_tap0    <= '0;
      rear_tap1    <= '0;
      fwd_tap0     <= '0;
      fwd_tap1     <= '0;
      rear_limit0  <= upz_pkg::REAR_LIMIT0_RST;
      rear_limit1  <= upz_pkg::REAR_LIMIT1_RST;
      rear_limit2  <= upz_pkg::REAR_LIMIT2_RST;
      fwd_limit0   <= upz_pkg::FWD_LIMIT0_RST;
      fwd_limit1   <= upz_pkg::FWD_LIMIT1_RST;
      setup_flag   <= 1'b0;
      channel_flag <= 1'b0;
      rear_step    <= RSTEP_FIRST;
      fwd_step     <= 1'b0;
    end else if (pop) begin
      rear_tap0    <= item.rear_cm;
      rear_tap1    <= rear_tap0;
      fwd_tap0     <= item.forward_cm;
      fwd_tap1     <= fwd_tap0;
      rear_limit0  <= rear_limit0_next;
      rear_limit1  <= rear_limit1_next;
      rear_limit2  <= rear_limit2_next;
      fwd_limit0   <= fwd_limit0_next;
      fwd_limit1   <= fwd_limit1_next;
      setup_flag   <= setup_flag_next;
      channel_flag <= channel_flag_next;
      rear_step    <= rear_step_next;
      fwd_step     <= fwd_step_next;
    end
  end

  // Output register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (pop) begin
      result.rear_distance    <= rd;
      result.forward_distance <= fd;
      result.shown_channel    <= channel_flag_next;
      result.in_setup         <= setup_flag_next;
      result.lamp             <= lamp;
      result.alert            <= alert;
      result.rejected         <= rej;
    end
  end

  // A refused capture leaves the block in setup mode
  a_reject_in_setup: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.rejected |-> result.in_setup)
    else $error("rejected result outside setup mode");

  // Alerts only in user mode on the forward channel
  a_alert_user_fwd: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result.alert != upz_pkg::ALERT_NONE)
      |-> !result.in_setup && result.shown_channel)
    else $error("alert outside user mode forward channel");

  // The green lamp only in user mode on the rear channel
  a_green_user_rear: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result.lamp == upz_pkg::LAMP_GREEN)
      |-> !result.in_setup && !result.shown_channel)
    else $error("green lamp outside user mode rear channel");

  // Hold a stalled result steady until it is taken
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result))
    else $error("stalled result changed or dropped");

endmodule

`default_nettype wire

// ===== rtl/core/ultrasonic_proximity_zoner.sv =====
// Ultrasonic proximity zoner: front divider, item queue and back decision stage.
// Path: an accepted item passes the front register, a queue entry and the output
//   register, and a result waits in the output register while the output stalls.
// Throughput: one item per cycle while nothing stalls; front and back each stall on
//   their own through a two-entry queue, and the output register fills while stalled.
// Reset: synchronous rst empties the pipeline, zeroes the filter history and
//   restores thresholds 10/20/30 rear and 20/40 forward, user mode, rear shown.
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_proximity_zoner (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output      logic                            in_stall,
  input  wire logic [upz_pkg::ECHO_W-1:0]      rear_echo_count,
  input  wire logic [upz_pkg::ECHO_W-1:0]      forward_echo_count,
  input  wire logic                            mode_press,
  input  wire logic                            select_press,
  output      logic                            out_valid,
  input  wire logic                            out_stall,
  output      logic [upz_pkg::DIST_W-1:0]      rear_distance,
  output      logic [upz_pkg::DIST_W-1:0]      forward_distance,
  output      logic                            shown_channel,
  output      logic                            in_setup,
  output      logic [upz_pkg::LAMP_W-1:0]      lamp,
  output      logic [upz_pkg::ALERT_W-1:0]     alert,
  output      logic                            rejected
);

  logic                 push;
  logic                 pop;
  logic                 queue_full;
  logic                 queue_empty;
  upz_pkg::upz_item_t   front_item;
  upz_pkg::upz_item_t   back_item;
  upz_pkg::upz_result_t result;

  upz_front u_front (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .rear_echo_count    (rear_echo_count),
    .forward_echo_count (forward_echo_count),
    .mode_press         (mode_press),
    .select_press       (select_press),
    .push               (push),
    .item               (front_item),
    .queue_full         (queue_full)
  );

  upz_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_item),
    .full  (queue_full),
    .pop   (pop),
    .dout  (back_item),
    .empty (queue_empty)
  );

  upz_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .item        (back_item),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result      (result)
  );

  // Unpack the result item onto its ports
  assign rear_distance    = result.rear_distance;
  assign forward_distance = result.forward_distance;
  assign shown_channel    = result.shown_channel;
  assign in_setup         = result.in_setup;
  assign lamp             = result.lamp;
  assign alert            = result.alert;
  assign rejected         = result.rejected;

endmodule

`default_nettype wire

// ===== verif/ultrasonic_proximity_zoner_test.sv =====
// Self-checking testbench for the ultrasonic proximity zoner.
`timescale 1ns / 1ps

module ultrasonic_proximity_zoner_test;
  import upz_pkg::*;

  localparam int unsigned CLK_PERIOD     = 12;
  localparam int unsigned RESET_CYCLES   = 4;
  localparam int unsigned PHASE_ITEMS    = 290;
  localparam int unsigned NUM_PHASES     = 5;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES    = 8;
  localparam int unsigned CM_TICKS       = 58;
  localparam int unsigned DIST_MAX       = 1129;

  // Idle and stall percentages per phase; phase 0 carries the directed items
  localparam int unsigned SEND_IDLE_PCT [NUM_PHASES] = '{0, 0, 69, 0, 12};
  localparam int unsigned RECV_STALL_PCT[NUM_PHASES] = '{0, 0, 0, 69, 12};

  typedef struct packed {
    logic [ECHO_W-1:0] rear_echo;
    logic [ECHO_W-1:0] fwd_echo;
    logic              mode_p;
    logic              sel_p;
  } echo_item_t;

  typedef struct packed {
    logic [2:0][DIST_W-1:0] rear_ring;
    logic [2:0][DIST_W-1:0] fwd_ring;
    logic [1:0]             slot;
    logic [2:0][DIST_W-1:0] rear_lim;
    logic [1:0][DIST_W-1:0] fwd_lim;
    logic                   setup;
    logic                   channel;
    logic [1:0]             rear_step;
    logic                   fwd_step;
  } zoner_state_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [ECHO_W-1:0]     rear_echo_count = '0;
  logic [ECHO_W-1:0]     forward_echo_count = '0;
  logic                  mode_press = 1'b0;
  logic                  select_press = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [DIST_W-1:0]     rear_distance;
  logic [DIST_W-1:0]     forward_distance;
  logic                  shown_channel;
  logic                  in_setup;
  logic [LAMP_W-1:0]     lamp;
  logic [ALERT_W-1:0]    alert;
  logic                  rejected;

  echo_item_t            echo_queue[$];
  upz_result_t           zone_queue[$];
  echo_item_t            sent_item;
  zoner_state_t          gen_st;
  zoner_state_t          chk_st;
  int unsigned           items_queued = 0;
  int unsigned           mismatches = 0;
  int unsigned           quiet_cycles = 0;
  int unsigned           send_idle_pct = 0;
  int unsigned           recv_stall_pct = 0;

  ultrasonic_proximity_zoner dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .rear_echo_count    (rear_echo_count),
    .forward_echo_count (forward_echo_count),
    .mode_press         (mode_press),
    .select_press       (select_press),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .rear_distance      (rear_distance),
    .forward_distance   (forward_distance),
    .shown_channel      (shown_channel),
    .in_setup           (in_setup),
    .lamp               (lamp),
    .alert              (alert),
    .rejected           (rejected)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // State right after reset: empty history, default thresholds, user mode, rear shown
  function automatic zoner_state_t power_on_state();
    zoner_state_t st;
    st = '0;
    st.rear_lim[0] = REAR_LIMIT0_RST;
    st.rear_lim[1] = REAR_LIMIT1_RST;
    st.rear_lim[2] = REAR_LIMIT2_RST;
    st.fwd_lim[0]  = FWD_LIMIT0_RST;
    st.fwd_lim[1]  = FWD_LIMIT1_RST;
    return st;
  endfunction

  // Weight the middle entry by four against the oldest and newest, divide by six
  function automatic logic [DIST_W-1:0] smooth(logic [2:0][DIST_W-1:0] ring,
                                               int unsigned cur);
    int unsigned sum;
    sum = 32'(ring[(cur + 1) % 3]) + 4 * 32'(ring[(cur + 2) % 3]) + 32'(ring[cur]);
    return DIST_W'(sum / 6);
  endfunction

  // Advance the zoner state by one item and return the result it produces
  function automatic upz_result_t zone_item(inout zoner_state_t st, input echo_item_t it);
    upz_result_t       res;
    int unsigned       cur;
    logic [DIST_W-1:0] rd;
    logic [DIST_W-1:0] fd;
    res = '0;
    cur = st.slot % 3;
    st.rear_ring[cur] = DIST_W'(it.rear_echo / CM_TICKS);
    st.fwd_ring[cur]  = DIST_W'(it.fwd_echo / CM_TICKS);
    rd = smooth(st.rear_ring, cur);
    fd = smooth(st.fwd_ring, cur);
    st.slot = 2'((cur + 1) % 3);

    // Mode press toggles the mode and restarts any capture sequence
    if (it.mode_p) begin
      st.setup     = ~st.setup;
      st.rear_step = '0;
      st.fwd_step  = 1'b0;
    end

    // Select swaps the channel in user mode, captures a threshold in setup mode
    if (it.sel_p) begin
      if (!st.setup) begin
        st.channel = ~st.channel;
      end else if (!st.channel) begin
        case (st.rear_step)
          2'd0: begin
            st.rear_lim[0] = rd;
            st.rear_step   = 2'd1;
          end
          2'd1: begin
            if (rd <= st.rear_lim[0]) begin
              res.rejected = 1'b1;
            end else begin
              st.rear_lim[1] = rd;
              st.rear_step   = 2'd2;
            end
          end
          2'd2: begin
            if (rd <= st.rear_lim[1]) begin
              res.rejected = 1'b1;
            end else begin
              st.rear_lim[2] = rd;
              st.rear_step   = 2'd0;
              st.setup       = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end else if (!st.fwd_step) begin
        st.fwd_lim[0] = fd;
        st.fwd_step   = 1'b1;
      end else if (fd <= st.fwd_lim[0]) begin
        res.rejected = 1'b1;
      end else begin
        st.fwd_lim[1] = fd;
        st.fwd_step   = 1'b0;
        st.setup      = 1'b0;
      end
    end

    // Lamp and alert from the updated state
    res.lamp  = LAMP_OFF;
    res.alert = ALERT_NONE;
    if (!st.setup) begin
      if (!st.channel) begin
        if (rd <= st.rear_lim[0])      res.lamp = LAMP_RED;
        else if (rd <= st.rear_lim[1]) res.lamp = LAMP_ORANGE;
        else if (rd <= st.rear_lim[2]) res.lamp = LAMP_YELLOW;
        else                           res.lamp = LAMP_GREEN;
      end else begin
        if (fd <= st.fwd_lim[0])      res.alert = ALERT_QUAD;
        else if (fd <= st.fwd_lim[1]) res.alert = ALERT_DOUBLE;
      end
    end else if (!st.channel) begin
      case (st.rear_step)
        2'd0:    res.lamp = LAMP_RED;
        2'd1:    res.lamp = LAMP_ORANGE;
        2'd2:    res.lamp = LAMP_YELLOW;
        default: res.lamp = LAMP_OFF;
      endcase
    end else begin
      res.lamp = st.fwd_step ? LAMP_ORANGE : LAMP_RED;
    end

    res.rear_distance    = rd;
    res.forward_distance = fd;
    res.shown_channel    = st.channel;
    res.in_setup         = st.setup;
    return res;
  endfunction

  // Queue one item and track the state it leaves behind, so sequences can be steered
  task automatic add_item(input logic [ECHO_W-1:0] rear, input logic [ECHO_W-1:0] fwd,
                          input logic mode_p, input logic sel_p);
    echo_item_t  it;
    upz_result_t ignored;
    it.rear_echo = rear;
    it.fwd_echo  = fwd;
    it.mode_p    = mode_p;
    it.sel_p     = sel_p;
    ignored = zone_item(gen_st, it);
    echo_queue.push_back(it);
    items_queued++;
  endtask

  function automatic logic [ECHO_W-1:0] cm_echo(int unsigned dist_cm);
    return ECHO_W'(dist_cm * CM_TICKS);
  endfunction

  // Echo width that lands on a given distance, with random sub-centimetre ticks
  function automatic logic [ECHO_W-1:0] level_echo(int unsigned dist_cm);
    int unsigned ticks;
    ticks = dist_cm * CM_TICKS + $urandom_range(CM_TICKS - 1);
    if (ticks > 32'hFFFF) ticks = 32'hFFFF;
    return ECHO_W'(ticks);
  endfunction

  // Mostly short ranges near the thresholds, some full-range, some edge values
  function automatic logic [ECHO_W-1:0] rand_echo();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60) return ECHO_W'($urandom_range(4000));
    if (pick < 85) return ECHO_W'($urandom);
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      2:       return ECHO_W'(CM_TICKS - 1);
      default: return ECHO_W'(CM_TICKS);
    endcase
  endfunction

  // User-mode traffic with occasional channel swaps and a rare mode press
  task automatic user_burst();
    int unsigned n;
    n = $urandom_range(3, 12);
    repeat (n) begin
      add_item(rand_echo(), rand_echo(), $urandom_range(29) == 0, $urandom_range(7) == 0);
    end
  endtask

  // Enter setup, then hold steady levels and capture, mostly ascending
  task automatic setup_episode();
    int unsigned lvl;
    int unsigned attempts;
    int unsigned hold;
    logic        mode_noise;
    if (!gen_st.setup) add_item(rand_echo(), rand_echo(), 1'b1, 1'b0);
    lvl = $urandom_range(0, 300);
    attempts = 0;
    while (gen_st.setup && attempts < 6) begin
      hold = $urandom_range(1, 3);
      for (int k = 0; k <= hold; k++) begin
        mode_noise = (k != hold) && ($urandom_range(19) == 0);
        if (gen_st.channel) add_item(rand_echo(), level_echo(lvl), mode_noise, k == hold);
        else                add_item(level_echo(lvl), rand_echo(), mode_noise, k == hold);
      end
      attempts++;
      // Drop below the last level now and then to provoke a refusal
      if ($urandom_range(4) == 0) begin
        lvl = $urandom_range(0, lvl);
      end else begin
        lvl = lvl + $urandom_range(1, 300);
        if (lvl > DIST_MAX) lvl = DIST_MAX;
      end
    end
  endtask

  task automatic fill_phase(input int unsigned count);
    int unsigned goal;
    int unsigned pick;
    goal = items_queued + count;
    while (items_queued < goal) begin
      pick = $urandom_range(99);
      if (pick < 45)      user_burst();
      else if (pick < 85) setup_episode();
      else add_item(ECHO_W'($urandom), ECHO_W'($urandom), $urandom_range(3) == 0,
                    $urandom_range(1) == 1);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Driver: predict on each accepted item, then load the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) zone_queue.push_back(zone_item(chk_st, sent_item));
      if (!in_valid || !in_stall) begin
        if (echo_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          sent_item = echo_queue.pop_front();
          rear_echo_count    <= sent_item.rear_echo;
          forward_echo_count <= sent_item.fwd_echo;
          mode_press         <= sent_item.mode_p;
          select_press       <= sent_item.sel_p;
          in_valid           <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random and compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    upz_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
      if (out_valid && !out_stall) begin
        if (zone_queue.size() == 0) begin
          $display("%0t: unexpected result: rear %0d forward %0d lamp %0d", $time,
                   rear_distance, forward_distance, lamp);
          mismatches++;
        end else begin
          want = zone_queue.pop_front();
          check_field("rear_distance", want.rear_distance, rear_distance);
          check_field("forward_distance", want.forward_distance, forward_distance);
          check_field("shown_channel", want.shown_channel, shown_channel);
          check_field("in_setup", want.in_setup, in_setup);
          check_field("lamp", want.lamp, lamp);
          check_field("alert", want.alert, alert);
          check_field("rejected", want.rejected, rejected);
        end
      end
    end
  end

  // Watchdog: end the run when neither side moves an item for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT - 1) begin
      $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus: reset, directed items, then random phases with a full drain between them
  initial begin
    gen_st = power_on_state();
    chk_st = power_on_state();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct  = SEND_IDLE_PCT[p];
      recv_stall_pct = RECV_STALL_PCT[p];
      if (p == 0) begin
        // Empty history, field extremes and the divide boundary
        add_item('0, '0, 1'b0, 1'b0);
        add_item('1, '1, 1'b0, 1'b0);
        add_item('1, '0, 1'b0, 1'b0);
        add_item(ECHO_W'(CM_TICKS - 1), ECHO_W'(CM_TICKS), 1'b0, 1'b0);
        // Swap to forward and back in user mode
        add_item(cm_echo(12), cm_echo(30), 1'b0, 1'b1);
        add_item(cm_echo(12), cm_echo(30), 1'b0, 1'b0);
        add_item(cm_echo(12), cm_echo(30), 1'b0, 1'b1);
        // Both buttons at once: enter setup and capture the first rear threshold
        add_item(cm_echo(1), cm_echo(1), 1'b1, 1'b1);
        // Refuse a lower capture, accept a higher one, refuse an equal one
        add_item(cm_echo(3), '0, 1'b0, 1'b0);
        add_item(cm_echo(3), '0, 1'b0, 1'b1);
        add_item(cm_echo(40), '0, 1'b0, 1'b0);
        add_item(cm_echo(40), '0, 1'b0, 1'b0);
        add_item(cm_echo(40), '0, 1'b0, 1'b1);
        add_item(cm_echo(40), '0, 1'b0, 1'b1);
        // Last rear capture returns to user mode
        add_item(cm_echo(90), '0, 1'b0, 1'b0);
        add_item(cm_echo(90), '0, 1'b0, 1'b0);
        add_item(cm_echo(90), '0, 1'b0, 1'b1);
        // Forward channel setup: capture, refuse, capture
        add_item('0, '0, 1'b0, 1'b1);
        add_item('0, cm_echo(5), 1'b1, 1'b0);
        add_item('0, cm_echo(5), 1'b0, 1'b1);
        add_item('0, cm_echo(2), 1'b0, 1'b1);
        add_item('0, cm_echo(60), 1'b0, 1'b0);
        add_item('0, cm_echo(60), 1'b0, 1'b1);
        // Enter setup and leave it by the mode button alone
        add_item('0, cm_echo(60), 1'b1, 1'b0);
        add_item('0, '0, 1'b1, 1'b0);
      end else begin
        fill_phase(PHASE_ITEMS);
      end
      // Hold off the next phase until every predicted result has come back
      while (echo_queue.size() != 0 || in_valid || zone_queue.size() != 0) @(negedge clk);
    end
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
